/* design/tpt_pkg.sv */
// Shared types and fixed widths for the TLB translator.
package tpt_pkg;

    localparam int VA_W   = 16;  // virtual address width
    localparam int PA_W   = 15;  // physical address port width
    localparam int SLOT_W = 4;   // TLB slot port width
    localparam int CNT_W  = 32;  // running counter width

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write one page-map entry of the clearing sweep
        logic accept;  // capture the incoming address
        logic lookup;  // TLB compare, page-map read data in hand
        logic commit;  // frame check, table updates, result register load
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // sweep address at the last page-map entry
    } t_status;

endpackage

/* design/tpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tpt_ctrl.sv */
// Sequencing state machine for the TLB translator.
module tpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tpt_pkg::t_status i_status,
    output tpt_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import tpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            ST_LOOKUP: o_cmd.lookup = 1'b1;
            ST_COMMIT: o_cmd.commit = 1'b1;
            default:   o_busy = 1'b1;
        endcase
    end

endmodule

/* design/tpt_datapath.sv */
// TLB, page map, frame table, pointers, counters and result registers.
module tpt_datapath #(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 128,
    parameter int OFFSET_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tpt_pkg::t_cmd               i_cmd,
    input  logic [tpt_pkg::VA_W-1:0]    i_virtual_address,
    output tpt_pkg::t_status            o_status,
    output logic                        o_result_valid,
    output logic [tpt_pkg::PA_W-1:0]    o_physical_address,
    output logic                        o_tlb_hit,
    output logic                        o_page_fault,
    output logic [tpt_pkg::SLOT_W-1:0]  o_tlb_slot,
    output logic [tpt_pkg::CNT_W-1:0]   o_translated_total,
    output logic [tpt_pkg::CNT_W-1:0]   o_hit_total,
    output logic [tpt_pkg::CNT_W-1:0]   o_fault_total
);
    import tpt_pkg::*;

    localparam int PAGE_W   = VA_W - OFFSET_BITS;
    localparam int FRAME_W  = $clog2(FRAME_COUNT);
    localparam int TLB_W    = $clog2(TLB_ENTRIES);
    localparam int PT_DEPTH = 1 << PAGE_W;
    localparam int PAEXT_W  = PA_W + FRAME_W + OFFSET_BITS;
    localparam int SLEXT_W  = SLOT_W + TLB_W;

    // captured request
    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_BITS-1:0] r_offset;

    // TLB
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [TLB_ENTRIES-1:0] n_tlb_valid;
    logic [PAGE_W-1:0]      r_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];
    logic [TLB_W-1:0]       r_tlb_ptr;
    logic [FRAME_W-1:0]     r_frame_ptr;

    // lookup stage results
    logic                   lk_hit;
    logic [TLB_W-1:0]       lk_slot;
    logic [FRAME_W-1:0]     lk_frame;
    logic                   r_hit;
    logic [TLB_W-1:0]       r_hit_slot;
    logic [FRAME_W-1:0]     r_hit_frame;
    logic                   r_pt_valid;
    logic [FRAME_W-1:0]     r_pt_frame;

    // memories
    logic [PAGE_W-1:0]      r_clr_addr;
    logic                   pt_we;
    logic [PAGE_W-1:0]      pt_waddr;
    logic [FRAME_W:0]       pt_wdata;
    logic [FRAME_W:0]       pt_rdata;
    logic                   fp_we;
    logic [PAGE_W-1:0]      fp_rdata;

    // commit stage
    logic                   cm_found;
    logic                   cm_fault;
    logic [FRAME_W-1:0]     cm_frame;
    logic [TLB_W-1:0]       cm_slot;
    logic [PAEXT_W-1:0]     cm_pa_ext;
    logic [SLEXT_W-1:0]     cm_slot_ext;

    // counters and result
    logic [CNT_W-1:0]       r_translated;
    logic [CNT_W-1:0]       r_hits;
    logic [CNT_W-1:0]       r_faults;
    logic                   r_out_valid;
    logic [PA_W-1:0]        r_out_pa;
    logic                   r_out_hit;
    logic                   r_out_fault;
    logic [SLOT_W-1:0]      r_out_slot;

    // page -> frame map, {valid, frame}; cleared by the sweep after reset
    tpt_ram #(
        .WIDTH (FRAME_W + 1),
        .DEPTH (PT_DEPTH)
    ) u_page_map (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (i_virtual_address[VA_W-1:OFFSET_BITS]),
        .o_rdata (pt_rdata)
    );

    // inverted frame table: page held by each frame
    tpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (FRAME_COUNT)
    ) u_frame_page (
        .i_clk   (i_clk),
        .i_we    (fp_we),
        .i_waddr (r_frame_ptr),
        .i_wdata (r_page),
        .i_raddr (pt_rdata[FRAME_W-1:0]),
        .o_rdata (fp_rdata)
    );

    assign pt_we    = i_cmd.clear | (i_cmd.commit & cm_fault);
    assign pt_waddr = i_cmd.clear ? r_clr_addr : r_page;
    assign pt_wdata = i_cmd.clear ? '0 : {1'b1, r_frame_ptr};
    assign fp_we    = i_cmd.commit & cm_fault;

    assign o_status.clear_last = &r_clr_addr;

    // parallel TLB compare, lowest matching slot wins
    always_comb begin
        lk_hit   = 1'b0;
        lk_slot  = '0;
        lk_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_page[i] == r_page)) begin
                lk_hit   = 1'b1;
                lk_slot  = TLB_W'(i);
                lk_frame = r_tlb_frame[i];
            end
        end
    end

    // a mapped page is live only while its frame still holds it
    assign cm_found    = r_pt_valid && (fp_rdata == r_page);
    assign cm_fault    = !r_hit && !cm_found;
    assign cm_frame    = r_hit ? r_hit_frame : (cm_found ? r_pt_frame : r_frame_ptr);
    assign cm_slot     = r_hit ? r_hit_slot : r_tlb_ptr;
    assign cm_pa_ext   = {PA_W'(0), cm_frame, r_offset};
    assign cm_slot_ext = {SLOT_W'(0), cm_slot};

    always_comb begin
        n_tlb_valid = r_tlb_valid;
        if (i_cmd.commit && !r_hit) begin
            // frame reuse drops stale entries before the new fill
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (cm_fault && r_tlb_valid[i] && (r_tlb_frame[i] == r_frame_ptr)) begin
                    n_tlb_valid[i] = 1'b0;
                end
            end
            n_tlb_valid[r_tlb_ptr] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid  <= '0;
            r_tlb_ptr    <= '0;
            r_frame_ptr  <= '0;
            r_translated <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_tlb_valid <= n_tlb_valid;
            r_out_valid <= i_cmd.commit;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + PAGE_W'(1);
            end
            if (i_cmd.commit) begin
                if (r_translated != '1) begin
                    r_translated <= r_translated + CNT_W'(1);
                end
                if (r_hit && (r_hits != '1)) begin
                    r_hits <= r_hits + CNT_W'(1);
                end
                if (cm_fault && (r_faults != '1)) begin
                    r_faults <= r_faults + CNT_W'(1);
                end
                if (!r_hit) begin
                    r_tlb_ptr <= (r_tlb_ptr == TLB_W'(TLB_ENTRIES - 1)) ? '0
                                 : r_tlb_ptr + TLB_W'(1);
                end
                if (cm_fault) begin
                    r_frame_ptr <= (r_frame_ptr == FRAME_W'(FRAME_COUNT - 1)) ? '0
                                   : r_frame_ptr + FRAME_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page   <= i_virtual_address[VA_W-1:OFFSET_BITS];
            r_offset <= i_virtual_address[OFFSET_BITS-1:0];
        end
        if (i_cmd.lookup) begin
            r_hit       <= lk_hit;
            r_hit_slot  <= lk_slot;
            r_hit_frame <= lk_frame;
            r_pt_valid  <= pt_rdata[FRAME_W];
            r_pt_frame  <= pt_rdata[FRAME_W-1:0];
        end
        if (i_cmd.commit) begin
            if (!r_hit) begin
                r_tlb_page[r_tlb_ptr]  <= r_page;
                r_tlb_frame[r_tlb_ptr] <= cm_frame;
            end
            r_out_pa    <= cm_pa_ext[PA_W-1:0];
            r_out_hit   <= r_hit;
            r_out_fault <= cm_fault;
            r_out_slot  <= cm_slot_ext[SLOT_W-1:0];
        end
    end

    assign o_result_valid     = r_out_valid;
    assign o_physical_address = r_out_pa;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_tlb_slot         = r_out_slot;
    assign o_translated_total = r_translated;
    assign o_hit_total        = r_hits;
    assign o_fault_total      = r_faults;

endmodule

/* design/tlb_page_table_translator.sv */
// Top level of the TLB address translator with FIFO replacement.
//
//  channel  | direction | transfer when                  | payload
//  ---------+-----------+--------------------------------+--------------------------------
//  request  | in        | start high while busy low      | i_virtual_address
//  result   | out       | o_result_valid high (1 cycle)  | o_physical_address, o_tlb_hit,
//           |           |                                | o_page_fault, o_tlb_slot,
//           |           |                                | o_*_total counters
//
//  Cycles: 3 per translation. Accept edge (page-map read issued), lookup
//  (TLB compare, frame-table read), commit (tables, pointers, counters and
//  result registers updated). The result strobe is high the cycle after
//  commit; busy is already low then, so a new start may transfer in that
//  cycle. The chain of two registered RAM reads sets this figure.
//  Reset: after i_rst_n releases, the page map is swept clear, one entry per
//  cycle, 2**(16-OFFSET_BITS) cycles (256 at default); busy stays high.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
//  Frame lookup uses a direct page -> frame map confirmed against the inverted
//  frame table, so a frame reassigned to another page no longer matches.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_COUNT = 128,
    parameter int OFFSET_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tpt_pkg::VA_W-1:0]    i_virtual_address,
    output logic                        o_result_valid,
    output logic [tpt_pkg::PA_W-1:0]    o_physical_address,
    output logic                        o_tlb_hit,
    output logic                        o_page_fault,
    output logic [tpt_pkg::SLOT_W-1:0]  o_tlb_slot,
    output logic [tpt_pkg::CNT_W-1:0]   o_translated_total,
    output logic [tpt_pkg::CNT_W-1:0]   o_hit_total,
    output logic [tpt_pkg::CNT_W-1:0]   o_fault_total
);
    import tpt_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: clear sweep, then accept / lookup / commit per request
    tpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAME_COUNT (FRAME_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_virtual_address  (i_virtual_address),
        .o_status           (status),
        .o_result_valid     (o_result_valid),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_tlb_slot         (o_tlb_slot),
        .o_translated_total (o_translated_total),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

endmodule
